FILE: src/bdsd_pkg.sv
package bdsd_pkg;

  localparam int unsigned DateW  = 24;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 7;
  localparam int unsigned DayW   = 7;
  localparam int unsigned MdayW  = 9;

  localparam logic [SpanW-1:0] DaysPerYear = 16'd365;

  // one date after bcd decode
  typedef struct packed {
    logic              ok;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_fields_t;

  function automatic logic bcd_byte_ok(input logic [7:0] b);
    return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  function automatic logic [7:0] bcd_byte_value(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
  endfunction

  function automatic date_fields_t decode_date(input logic [DateW-1:0] date);
    date_fields_t f;
    logic [7:0]   yv;
    logic [7:0]   mv;
    logic [7:0]   dv;
    yv      = bcd_byte_value(date[23:16]);
    mv      = bcd_byte_value(date[15:8]);
    dv      = bcd_byte_value(date[7:0]);
    f.ok    = bcd_byte_ok(date[23:16]) && bcd_byte_ok(date[15:8]) &&
              bcd_byte_ok(date[7:0]) && (mv >= 8'd1) && (mv <= 8'd12) &&
              (dv != 8'd0);
    f.year  = yv[YearW-1:0];
    f.month = mv[MonthW-1:0];
    f.day   = dv[DayW-1:0];
    return f;
  endfunction

  // days before the first of each month, common year
  function automatic logic [MdayW-1:0] days_before_month(input logic [MonthW-1:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

FILE: src/bcd_date_span_days_core.sv
// throughput: one date pair per cycle; a stalled output holds the whole pipe
// stages: bcd decode, year/month partial counts, day counts, difference
// reset: rst_n synchronous active low clears the stage valid bits only
module bcd_date_span_days_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] start_date, [47:24] stop_date
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] span_days
  output logic        out_tuser   // [0] date_error
);

  // whole pipe advances together whenever the output slot is free or drains
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: decoded dates and raw order compare
  bdsd_pkg::date_fields_t b1_r, e1_r;
  logic                   lt1_r;

  // stage 2: year part and in-year part of each count
  logic [bdsd_pkg::SpanW-1:0] by2_r, ey2_r;
  logic [bdsd_pkg::MdayW-1:0] bm2_r, em2_r;
  logic                       ok2_r, lt2_r;

  // stage 3: full day counts
  logic [bdsd_pkg::SpanW-1:0] bd3_r, ed3_r;
  logic                       ok3_r, lt3_r;

  // stage 4: output register
  logic [bdsd_pkg::SpanW-1:0] span4_r;
  logic                       err4_r;

  // year part: y*365 plus leap years before it (every fourth within 2000..2099)
  function automatic logic [bdsd_pkg::SpanW-1:0] year_days(
      input logic [bdsd_pkg::YearW-1:0] y);
    logic [bdsd_pkg::SpanW-1:0] yw;
    logic [bdsd_pkg::SpanW-1:0] leaps;
    yw    = {{(bdsd_pkg::SpanW - bdsd_pkg::YearW){1'b0}}, y};
    leaps = (yw + 16'd3) >> 2;
    return yw * bdsd_pkg::DaysPerYear + leaps;
  endfunction

  // in-year part: month offset, leap february, day - 1
  function automatic logic [bdsd_pkg::MdayW-1:0] month_days(
      input bdsd_pkg::date_fields_t f);
    logic leap_adj;
    leap_adj = (f.year[1:0] == 2'd0) && (f.month > 4'd2);
    return bdsd_pkg::days_before_month(f.month) + {8'd0, leap_adj} +
           {2'd0, f.day} - 9'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      b1_r  <= bdsd_pkg::decode_date(in_tdata[23:0]);
      e1_r  <= bdsd_pkg::decode_date(in_tdata[47:24]);
      lt1_r <= in_tdata[23:0] < in_tdata[47:24];
      // stage 2
      by2_r <= year_days(b1_r.year);
      ey2_r <= year_days(e1_r.year);
      bm2_r <= month_days(b1_r);
      em2_r <= month_days(e1_r);
      ok2_r <= b1_r.ok && e1_r.ok;
      lt2_r <= lt1_r;
      // stage 3
      bd3_r <= by2_r + {{(bdsd_pkg::SpanW - bdsd_pkg::MdayW){1'b0}}, bm2_r};
      ed3_r <= ey2_r + {{(bdsd_pkg::SpanW - bdsd_pkg::MdayW){1'b0}}, em2_r};
      ok3_r <= ok2_r;
      lt3_r <= lt2_r;
      // stage 4: zero span unless both dates good and begin strictly earlier
      span4_r <= (ok3_r && lt3_r && (ed3_r > bd3_r)) ? (ed3_r - bd3_r) :
                 {bdsd_pkg::SpanW{1'b0}};
      err4_r  <= !ok3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = span4_r;
  assign out_tuser  = err4_r;

endmodule

FILE: src/bdsd_checker.sv
module bdsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a flagged date always comes with a zero span
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 16'd0)
    else $error("error result with nonzero span");

  // span never beyond a full century plus day overrun
  a_span_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd36592)
    else $error("span out of range");

  // an empty output slot never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind bcd_date_span_days_core bdsd_checker u_bdsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
